[rtl/sfd_pkg.sv]
// Shared types, constants and the CRC step for the stuffed frame deframer.
// No dependencies; used by stuffed_frame_deframer_crc16_unit.
package sfd_pkg;

    localparam int unsigned MAX_PAYLOAD  = 254;
    localparam int unsigned BUFFER_BYTES = 256;
    localparam int unsigned MIN_RAW      = 4;
    localparam int unsigned CRC_BYTES    = 2;
    localparam int unsigned CNT_W        = 9;

    localparam logic [CNT_W-1:0] BUFFER_LIMIT  = CNT_W'(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] UNSTUFFED_MAX = CNT_W'(MAX_PAYLOAD + CRC_BYTES);
    localparam logic [CNT_W-1:0] RAW_MIN       = CNT_W'(MIN_RAW);
    localparam logic [CNT_W-1:0] CRC_LEN       = CNT_W'(CRC_BYTES);

    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        EV_PAYLOAD  = 3'd0,
        EV_GOOD     = 3'd1,
        EV_CRC      = 3'd2,
        EV_SHORT    = 3'd3,
        EV_SYNC     = 3'd4,
        EV_NOSYNC   = 3'd5,
        EV_OVERFLOW = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        CFG_SYNC_CODE   = 3'd0,
        CFG_END_CODE    = 3'd1,
        CFG_ESCAPE_CODE = 3'd2,
        CFG_MAX_STUFFED = 3'd3,
        CFG_CRC_POLY    = 3'd4,
        CFG_CRC_INIT    = 3'd5
    } cfg_index_t;

    // MSB-first CRC-16 update over one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ poly;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

[rtl/stuffed_frame_deframer_crc16_unit.sv]
// Byte-stuffed frame deframer with CRC-16 check: top level.
// Depends on sfd_pkg for event codes, register indexes and the CRC step.
//
// Takes one raw received byte per request on the s_ side and gives at most one
// result per byte on the m_ side: an unstuffed payload byte or a frame status.
// The sustained rate is one byte per clock cycle unless m_tready stalls the output; a
// byte's result is registered in the input register and then the result register, with
// the unstuffing, counters and a byte-wide CRC update between them.
// Payload leaves through a two-byte delay so the trailing CRC bytes are never emitted.
// Write the configuration registers only while the block is idle.
module stuffed_frame_deframer_crc16_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream: tdata = rx_byte[7:0]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    // master stream: tdata = payload_byte[7:0], payload_length[15:8]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,
    // master stream: tuser = event_res[2:0]
    output logic [2:0]           m_tuser,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  sfd_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]          cfg_data
);
    import sfd_pkg::*;

    logic [7:0]  sync_code_reg;
    logic [7:0]  end_code_reg;
    logic [7:0]  escape_code_reg;
    logic [8:0]  max_stuffed_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_init_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic        in_frame_reg, in_frame_next;
    logic        esc_pend_reg, esc_pend_next;
    count_t      stuffed_reg, stuffed_next;
    count_t      unstuffed_reg, unstuffed_next;
    logic [7:0]  held0_reg, held0_next;
    logic [7:0]  held1_reg, held1_next;
    logic [15:0] crc_reg, crc_next;

    logic        out_valid_reg;
    event_t      out_event_reg;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_len_reg;

    logic        advance;
    logic        res_valid;
    event_t      res_event;
    logic [7:0]  res_byte;
    logic [7:0]  res_len;
    count_t      limit;
    count_t      len_full;
    logic [7:0]  val;
    logic        take_val;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_code_reg   <= 8'd2;
            end_code_reg    <= 8'd3;
            escape_code_reg <= 8'd16;
            max_stuffed_reg <= 9'd256;
            crc_poly_reg    <= 16'h1021;
            crc_init_reg    <= 16'h0000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_CODE:   sync_code_reg   <= cfg_data[7:0];
                CFG_END_CODE:    end_code_reg    <= cfg_data[7:0];
                CFG_ESCAPE_CODE: escape_code_reg <= cfg_data[7:0];
                CFG_MAX_STUFFED: max_stuffed_reg <= cfg_data[8:0];
                CFG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                CFG_CRC_INIT:    crc_init_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    assign limit    = (max_stuffed_reg > BUFFER_LIMIT) ? BUFFER_LIMIT : count_t'(max_stuffed_reg);
    assign len_full = unstuffed_reg - CRC_LEN;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        esc_pend_next  = esc_pend_reg;
        stuffed_next   = stuffed_reg;
        unstuffed_next = unstuffed_reg;
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        crc_next       = crc_reg;
        res_valid      = 1'b0;
        res_event      = EV_PAYLOAD;
        res_byte       = 8'd0;
        res_len        = 8'd0;
        val            = in_byte_reg;
        take_val       = 1'b0;

        if (!in_frame_reg)
        begin
            priority if (in_byte_reg == sync_code_reg)
            begin
                in_frame_next  = 1'b1;
                esc_pend_next  = 1'b0;
                stuffed_next   = count_t'(1);
                unstuffed_next = '0;
                held0_next     = 8'd0;
                held1_next     = 8'd0;
                crc_next       = crc_init_reg;
            end
            else if (in_byte_reg == end_code_reg)
            begin
                res_valid = 1'b1;
                res_event = EV_NOSYNC;
            end
            else
            begin
            end
        end
        else
        begin
            priority if (stuffed_reg >= limit)
            begin
                in_frame_next  = 1'b0;
                esc_pend_next  = 1'b0;
                stuffed_next   = '0;
                unstuffed_next = '0;
                res_valid      = 1'b1;
                res_event      = EV_OVERFLOW;
            end
            else if (in_byte_reg == sync_code_reg)
            begin
                esc_pend_next  = 1'b0;
                stuffed_next   = count_t'(1);
                unstuffed_next = '0;
                held0_next     = 8'd0;
                held1_next     = 8'd0;
                crc_next       = crc_init_reg;
                res_valid      = 1'b1;
                res_event      = EV_SYNC;
            end
            else if (in_byte_reg == end_code_reg)
            begin
                in_frame_next  = 1'b0;
                esc_pend_next  = 1'b0;
                stuffed_next   = '0;
                unstuffed_next = '0;
                res_valid      = 1'b1;
                priority if (stuffed_reg < RAW_MIN || unstuffed_reg < CRC_LEN)
                    res_event = EV_SHORT;
                else if ({held1_reg, held0_reg} != crc_reg)
                begin
                    res_event = EV_CRC;
                    res_len   = len_full[7:0];
                end
                else
                begin
                    res_event = EV_GOOD;
                    res_len   = len_full[7:0];
                end
            end
            else
            begin
                stuffed_next = stuffed_reg + count_t'(1);
                priority if (esc_pend_reg)
                begin
                    esc_pend_next = 1'b0;
                    val           = escape_code_reg + in_byte_reg;
                    take_val      = 1'b1;
                end
                else if (in_byte_reg == escape_code_reg)
                    esc_pend_next = 1'b1;
                else
                    take_val = 1'b1;

                if (take_val)
                begin
                    priority if (unstuffed_reg >= UNSTUFFED_MAX)
                    begin
                        in_frame_next  = 1'b0;
                        esc_pend_next  = 1'b0;
                        stuffed_next   = '0;
                        unstuffed_next = '0;
                        res_valid      = 1'b1;
                        res_event      = EV_OVERFLOW;
                    end
                    else
                    begin
                        unstuffed_next = unstuffed_reg + count_t'(1);
                        held0_next     = held1_reg;
                        held1_next     = val;
                        if (unstuffed_reg >= CRC_LEN)
                        begin
                            crc_next  = crc16_byte(crc_reg, held0_reg, crc_poly_reg);
                            res_valid = 1'b1;
                            res_event = EV_PAYLOAD;
                            res_byte  = held0_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            esc_pend_reg  <= 1'b0;
            stuffed_reg   <= '0;
            unstuffed_reg <= '0;
            held0_reg     <= 8'd0;
            held1_reg     <= 8'd0;
            crc_reg       <= 16'h0000;
        end
        else if (advance)
        begin
            in_frame_reg  <= in_frame_next;
            esc_pend_reg  <= esc_pend_next;
            stuffed_reg   <= stuffed_next;
            unstuffed_reg <= unstuffed_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_event_reg <= res_event;
            out_byte_reg  <= res_byte;
            out_len_reg   <= res_len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {out_len_reg, out_byte_reg};

    a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (stuffed_reg == '0 && unstuffed_reg == '0 && !esc_pend_reg))
        else $error("counters or escape left set outside a frame");

    a_unstuffed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unstuffed_reg <= UNSTUFFED_MAX)
        else $error("unstuffed count beyond payload limit");

    a_stuffed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stuffed_reg <= BUFFER_LIMIT)
        else $error("stuffed count beyond buffer size");

    a_len_only_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_event_reg != EV_GOOD && out_event_reg != EV_CRC)
            |-> out_len_reg == 8'd0)
        else $error("length reported on a non-status event");

    a_byte_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_event_reg != EV_PAYLOAD) |-> out_byte_reg == 8'd0)
        else $error("data byte reported on a status event");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for stuffed_frame_deframer_crc16_unit: directed and random byte streams,
// each accepted byte run through a local deframing and CRC-16 model, results checked in order.
// Depends on sfd_pkg and the top-level RTL only.
module tb;
    import sfd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        event_t     ev;
        logic [7:0] data;
        logic [7:0] len;
    } frame_event_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_SYNC_CODE;
    logic [15:0] cfg_data  = 16'h0000;

    logic [7:0]  sync_r;
    logic [7:0]  end_r;
    logic [7:0]  esc_r;
    count_t      max_len_r;
    logic [15:0] poly_r;
    logic [15:0] init_r;

    bit          in_frame_m;
    bit          esc_wait_m;
    count_t      raw_cnt_m;
    count_t      body_cnt_m;
    logic [7:0]  hold_old;
    logic [7:0]  hold_new;
    logic [15:0] crc_m;

    frame_event_t pending_events[$];
    logic [7:0]   frame_body[$];
    frame_event_t exp_r;
    int           errors      = 0;
    int           rx_sent     = 0;
    int           idle_cycles = 0;
    bit           src_gaps    = 1'b0;
    bit           sink_stalls = 1'b0;

    stuffed_frame_deframer_crc16_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // rx_byte[7:0]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // payload_byte[7:0], payload_length[15:8]
        .m_tuser   (m_tuser),      // event_res[2:0]
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ d[k];
            c  = {c[14:0], 1'b0};
            if (fb)
                c = c ^ poly_r;
        end
        return c;
    endfunction

    function automatic void post_event(input event_t ev, input logic [7:0] d,
                                       input logic [7:0] l);
        frame_event_t e;
        e.ev   = ev;
        e.data = d;
        e.len  = l;
        pending_events.push_back(e);
    endfunction

    function automatic void open_frame_m();
        in_frame_m = 1'b1;
        esc_wait_m = 1'b0;
        raw_cnt_m  = count_t'(1);
        body_cnt_m = '0;
        hold_old   = 8'h00;
        hold_new   = 8'h00;
        crc_m      = init_r;
    endfunction

    function automatic void close_frame_m();
        in_frame_m = 1'b0;
        esc_wait_m = 1'b0;
        raw_cnt_m  = '0;
        body_cnt_m = '0;
    endfunction

    function automatic void reset_shadow();
        sync_r    = 8'h02;
        end_r     = 8'h03;
        esc_r     = 8'h10;
        max_len_r = count_t'(256);
        poly_r    = 16'h1021;
        init_r    = 16'h0000;
        close_frame_m();
        hold_old  = 8'h00;
        hold_new  = 8'h00;
        crc_m     = init_r;
    endfunction

    // deframe one raw byte and queue the result it causes, if any
    function automatic void deframe_byte(input logic [7:0] b);
        count_t      cap;
        logic [7:0]  v;
        logic [15:0] supplied;
        cap = (max_len_r > BUFFER_LIMIT) ? BUFFER_LIMIT : max_len_r;
        if (!in_frame_m)
        begin
            if (b == sync_r)
                open_frame_m();
            else if (b == end_r)
                post_event(EV_NOSYNC, 8'h00, 8'h00);
            return;
        end
        if (raw_cnt_m >= cap)
        begin
            close_frame_m();
            post_event(EV_OVERFLOW, 8'h00, 8'h00);
            return;
        end
        if (b == sync_r)
        begin
            open_frame_m();
            post_event(EV_SYNC, 8'h00, 8'h00);
            return;
        end
        if (b == end_r)
        begin
            supplied = {hold_new, hold_old};
            if (raw_cnt_m < RAW_MIN || body_cnt_m < CRC_LEN)
                post_event(EV_SHORT, 8'h00, 8'h00);
            else if (supplied != crc_m)
                post_event(EV_CRC, 8'h00, 8'(body_cnt_m - CRC_LEN));
            else
                post_event(EV_GOOD, 8'h00, 8'(body_cnt_m - CRC_LEN));
            close_frame_m();
            return;
        end
        raw_cnt_m = raw_cnt_m + 1'b1;
        if (esc_wait_m)
        begin
            esc_wait_m = 1'b0;
            v = 8'(esc_r + b);
        end
        else if (b == esc_r)
        begin
            esc_wait_m = 1'b1;
            return;
        end
        else
            v = b;
        if (body_cnt_m >= UNSTUFFED_MAX)
        begin
            close_frame_m();
            post_event(EV_OVERFLOW, 8'h00, 8'h00);
            return;
        end
        body_cnt_m = body_cnt_m + 1'b1;
        if (body_cnt_m > CRC_LEN)
        begin
            post_event(EV_PAYLOAD, hold_old, 8'h00);
            crc_m = crc_step(crc_m, hold_old);
        end
        hold_old = hold_new;
        hold_new = v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 19))
            0: return sync_r;
            1: return end_r;
            2: return esc_r;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void fill_body(input int n);
        frame_body.delete();
        repeat (n) frame_body.push_back(pick_byte());
    endfunction

    function automatic void set_pacing();
        src_gaps    = ($urandom_range(0, 2) != 0);
        sink_stalls = ($urandom_range(0, 2) != 0);
    endfunction

    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = src_gaps ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        deframe_byte(b);
        rx_sent++;
    endtask

    task automatic send_stuffed(input logic [7:0] b);
        if (b == sync_r || b == end_r || b == esc_r || $urandom_range(0, 9) == 0)
        begin
            send_rx(esc_r);
            send_rx(8'(b - esc_r));
        end
        else
            send_rx(b);
    endtask

    // frame_body is the payload; the CRC is appended low byte first
    task automatic send_frame(input bit bad_crc, input bit dangle);
        logic [15:0] c;
        c = init_r;
        foreach (frame_body[i])
            c = crc_step(c, frame_body[i]);
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        send_rx(sync_r);
        foreach (frame_body[i])
            send_stuffed(frame_body[i]);
        send_stuffed(c[7:0]);
        send_stuffed(c[15:8]);
        if (dangle)
            send_rx(esc_r);
        send_rx(end_r);
    endtask

    task automatic run_frames(input int count, input int longest);
        repeat (count)
        begin
            fill_body($urandom_range(0, longest));
            send_frame($urandom_range(0, 5) == 0, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SYNC_CODE:   sync_r    = val[7:0];
            CFG_END_CODE:    end_r     = val[7:0];
            CFG_ESCAPE_CODE: esc_r     = val[7:0];
            CFG_MAX_STUFFED: max_len_r = val[8:0];
            CFG_CRC_POLY:    poly_r    = val;
            CFG_CRC_INIT:    init_r    = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                                input count_t lim, input logic [15:0] poly,
                                input logic [15:0] init);
        settle();
        write_reg(CFG_SYNC_CODE, {8'h00, s});
        write_reg(CFG_END_CODE, {8'h00, e});
        write_reg(CFG_ESCAPE_CODE, {8'h00, x});
        write_reg(CFG_MAX_STUFFED, {7'h00, lim});
        write_reg(CFG_CRC_POLY, poly);
        write_reg(CFG_CRC_INIT, init);
    endtask

    task automatic test_directed();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
        send_rx(8'h00);
        send_rx(8'hFF);
        send_rx(end_r);
        frame_body.delete();
        frame_body.push_back(8'h10);
        frame_body.push_back(8'h00);
        send_frame(1'b0, 1'b0);
        send_rx(sync_r);
        send_rx(8'h55);
        send_rx(end_r);
        // escape wraps past 0xFF, then a dangling escape before end
        send_rx(sync_r);
        send_rx(esc_r);
        send_rx(8'hFF);
        send_rx(8'hAA);
        send_rx(8'h11);
        send_rx(esc_r);
        send_rx(end_r);
        // sync after escape still restarts the frame
        send_rx(sync_r);
        send_rx(esc_r);
        send_rx(sync_r);
        send_rx(end_r);
    endtask

    task automatic test_length_limits();
        apply_config(8'h02, 8'h03, 8'h10, count_t'(MIN_RAW), 16'h1021, 16'h0000);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        send_rx(sync_r);
        send_rx(8'h41);
        send_rx(8'h42);
        send_rx(8'h43);
        send_rx(end_r);
        run_frames(8, 2);
        apply_config(8'h02, 8'h03, 8'h10, count_t'(MIN_RAW + 1), 16'h1021, 16'h0000);
        set_pacing();
        run_frames(8, 3);
        apply_config(8'h02, 8'h03, 8'h10, BUFFER_LIMIT, 16'h1021, 16'h0000);
        set_pacing();
        fill_body(MAX_PAYLOAD);
        send_frame(1'b0, 1'b0);
    endtask

    task automatic test_code_extremes();
        apply_config(8'h00, 8'hFF, 8'h80, BUFFER_LIMIT, 16'h1021, 16'h0000);
        set_pacing();
        run_frames(10, 8);
        // escape equal to sync: stuffed bytes become sync in frame
        apply_config(8'hFF, 8'h00, 8'hFF, BUFFER_LIMIT, 16'h1021, 16'h0000);
        set_pacing();
        run_frames(6, 6);
        apply_config(8'h7E, 8'h7D, 8'h7D, BUFFER_LIMIT, 16'h1021, 16'h0000);
        set_pacing();
        run_frames(6, 6);
        apply_config(8'h55, 8'h55, 8'h00, BUFFER_LIMIT, 16'h1021, 16'h0000);
        set_pacing();
        run_frames(4, 4);
    endtask

    task automatic test_crc_settings();
        apply_config(8'h02, 8'h03, 8'h10, BUFFER_LIMIT, 16'hFFFF, 16'hFFFF);
        set_pacing();
        run_frames(5, 8);
        apply_config(8'h02, 8'h03, 8'h10, BUFFER_LIMIT, 16'h0000, 16'h0000);
        set_pacing();
        run_frames(5, 8);
        apply_config(8'h02, 8'h03, 8'h10, BUFFER_LIMIT, 16'h8005, 16'h1D0F);
        set_pacing();
        run_frames(5, 8);
    endtask

    task automatic random_config();
        count_t lim;
        lim = ($urandom_range(0, 9) < 6) ? BUFFER_LIMIT
                                         : count_t'($urandom_range(MIN_RAW, BUFFER_BYTES));
        apply_config(8'($urandom), 8'($urandom), 8'($urandom), lim,
                     16'($urandom), 16'($urandom));
        set_pacing();
    endtask

    task automatic test_random_traffic();
        int kind;
        int n;
        int stop_at;
        stop_at = rx_sent + RANDOM_ITEMS;
        while (rx_sent < stop_at)
        begin
            if ($urandom_range(0, 39) == 0)
                random_config();
            kind = $urandom_range(0, 99);
            n = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 12) : $urandom_range(13, 256);
            fill_body(n);
            if (kind < 62)
                send_frame(1'b0, 1'b0);
            else if (kind < 72)
                send_frame(1'b1, 1'b0);
            else if (kind < 77)
                send_frame(1'b0, 1'b1);
            else if (kind < 83)
            begin
                send_rx(sync_r);
                repeat ($urandom_range(0, 2)) send_rx(pick_byte());
                send_rx(end_r);
            end
            else if (kind < 89)
                repeat ($urandom_range(1, 6)) send_rx(pick_byte());
            else if (kind < 93)
                send_rx(end_r);
            else
            begin
                // abandon a partial frame
                send_rx(sync_r);
                repeat ($urandom_range(1, 8)) send_rx(pick_byte());
            end
        end
    endtask

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result event_res %0d payload_byte %0h length %0d",
                         $time, m_tuser, m_tdata[7:0], m_tdata[15:8]);
                errors++;
            end
            else
            begin
                exp_r = pending_events.pop_front();
                if (m_tuser !== exp_r.ev)
                begin
                    $display("%0t: event_res expected %0d actual %0d",
                             $time, exp_r.ev, m_tuser);
                    errors++;
                end
                if (m_tdata[7:0] !== exp_r.data)
                begin
                    $display("%0t: payload_byte expected %0h actual %0h",
                             $time, exp_r.data, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== exp_r.len)
                begin
                    $display("%0t: payload_length expected %0d actual %0d",
                             $time, exp_r.len, m_tdata[15:8]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_length_limits();
        test_code_extremes();
        test_crc_settings();
        test_random_traffic();
        settle();
        if (pending_events.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_events.size());
            errors++;
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/sfd_pkg.sv
rtl/stuffed_frame_deframer_crc16_unit.sv
tb/sv/tb.sv
